### src/mwto_pkg.sv
`default_nettype none

package mwto_pkg;

    // phase and table geometry
    localparam int PHASE_BITS = 32;
    localparam int TABLE_BITS = 10;
    localparam int QSIZE      = 1 << TABLE_BITS;
    localparam int ADDR_BITS  = TABLE_BITS + 1;

    // datapath widths
    localparam int F_BITS    = 32;
    localparam int W_BITS    = 34;
    localparam int B_BITS    = 16;
    localparam int DIGIT     = 4;
    localparam int MUL_STEPS = B_BITS / DIGIT;
    localparam int STEP_BITS = $clog2(MUL_STEPS);
    localparam int P_BITS    = W_BITS + B_BITS;
    localparam int Q_SHIFT   = 30;
    localparam int Y_BITS    = P_BITS + 1 - Q_SHIFT;
    localparam int OUT_BITS  = 19;
    localparam int ROM_BITS  = 16;

    // configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PHASE_STEP  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AMPLITUDE   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WAVE_SELECT = 2'd2;

    // wave select codes
    localparam logic [2:0] WAVE_SQUARE    = 3'd0;
    localparam logic [2:0] WAVE_TRIANGLE  = 3'd1;
    localparam logic [2:0] WAVE_SAWTOOTH  = 3'd2;
    localparam logic [2:0] WAVE_SINE      = 3'd3;
    localparam logic [2:0] WAVE_COMPOSITE = 3'd4;
    localparam logic [2:0] WAVE_BELL      = 3'd5;

    // reset values of the registers
    localparam logic [31:0] RST_PHASE_STEP  = 32'd0;
    localparam logic [15:0] RST_AMPLITUDE   = 16'd32768;
    localparam logic [2:0]  RST_WAVE_SELECT = WAVE_COMPOSITE;

    // harmonic weights, Q1.15
    localparam logic [B_BITS-1:0] COEF_ONE   = 16'd32768;
    localparam logic [B_BITS-1:0] COEF_HALF  = 16'd16384;
    localparam logic [B_BITS-1:0] COEF_0_33  = 16'd10813;
    localparam logic [B_BITS-1:0] COEF_QUART = 16'd8192;
    localparam logic [B_BITS-1:0] COEF_0_16  = 16'd5243;
    localparam logic [B_BITS-1:0] COEF_0_13  = 16'd4260;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30_U   = 64'd1 << 30;

    typedef logic [ROM_BITS-1:0] t_rom [0:QSIZE];

    typedef struct packed {
        logic              start;
        logic [W_BITS-1:0] a;
        logic [B_BITS-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [P_BITS-1:0] prod;
    } t_mul_rsp;

    // quarter-wave sine, Taylor series in Q30, rounded to Q15
    function automatic t_rom f_fill_rom();
        t_rom        rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        for (int i = 0; i <= QSIZE; i++) begin
            x  = (64'(i) * HALF_PI_Q30) >> TABLE_BITS;
            x2 = (x * x) >> 30;
            t  = ONE_Q30_U - x2 / 72;
            t  = ONE_Q30_U - ((x2 * t) >> 30) / 42;
            t  = ONE_Q30_U - ((x2 * t) >> 30) / 20;
            t  = ONE_Q30_U - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            q  = (s + 64'd16384) >> 15;
            if (q > 64'd32768) begin
                q = 64'd32768;
            end
            rom[i] = q[ROM_BITS-1:0];
        end
        return rom;
    endfunction

    localparam t_rom C_SINE_ROM = f_fill_rom();

    // weight of harmonic k+1 for the selected wave
    function automatic logic [B_BITS-1:0] f_coef(input logic [2:0] sel, input logic [2:0] k);
        logic [B_BITS-1:0] c;
        c = COEF_ONE;
        if (sel == WAVE_COMPOSITE) begin
            case (k)
                3'd0:    c = COEF_ONE;
                3'd1:    c = COEF_HALF;
                3'd2:    c = COEF_QUART;
                default: c = COEF_ONE;
            endcase
        end else if (sel == WAVE_BELL) begin
            case (k)
                3'd0:    c = COEF_ONE;
                3'd1:    c = COEF_HALF;
                3'd2:    c = COEF_0_33;
                3'd3:    c = COEF_QUART;
                3'd4:    c = COEF_0_16;
                3'd5:    c = COEF_0_13;
                default: c = COEF_ONE;
            endcase
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### src/mwto_dmul.sv
`default_nettype none

// signed a times unsigned b, b taken one digit per cycle from its low end
module mwto_dmul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mwto_pkg::t_mul_req i_req,
    output mwto_pkg::t_mul_rsp o_rsp
);
    import mwto_pkg::*;

    logic signed [W_BITS-1:0]  r_a;
    logic signed [W_BITS-1:0]  r_hi;
    logic [B_BITS-1:0]         r_b;
    logic [STEP_BITS-1:0]      r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic signed [W_BITS+DIGIT:0] n_sum;

    // partial product of one digit plus the running high part
    assign n_sum = (W_BITS+DIGIT+1)'(r_hi)
                 + r_a * $signed({1'b0, r_b[DIGIT-1:0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= $signed(i_req.a);
                r_b    <= i_req.b;
                r_hi   <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_hi  <= n_sum[W_BITS+DIGIT-1:DIGIT];
                r_b   <= {n_sum[DIGIT-1:0], r_b[B_BITS-1:DIGIT]};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_BITS'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = {r_hi, r_b};

endmodule

`default_nettype wire

### src/multi_waveform_tone_oscillator_unit.sv
// an accepted tick request runs address, rom read and weight multiply once per sine harmonic
// (0 for square/triangle/sawtooth/unused, 1 sine, 3 composite, 6 bell), then the gain multiply
// and the output step, which waits while a held sample is stalled; a new request is taken only
// after that step; each product uses the shared 4-bit digit-serial multiplier (four steps)
// reset (synchronous, active low): phase 0, phase_step 0, amplitude 1.0, composite wave,
// no sample pending; the sine table is a constant rom and needs no clearing
`default_nettype none

module multi_waveform_tone_oscillator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [mwto_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [mwto_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    // tick request channel
    input  logic                               i_tick_valid,
    output logic                               o_tick_stall,
    input  logic                               i_tick,
    // sample channel
    output logic                               o_sample_valid,
    input  logic                               i_sample_stall,
    output logic signed [mwto_pkg::OUT_BITS-1:0] o_sample
);
    import mwto_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_ROM,
        S_HGO,
        S_HMUL,
        S_SCALE,
        S_AMUL,
        S_OUT
    } t_state;

    t_state r_state;

    // configuration registers
    logic [31:0] r_step;
    logic [15:0] r_amp;
    logic [2:0]  r_sel;

    // phase accumulator and per-sample working registers
    logic [PHASE_BITS-1:0]    r_phase;
    logic [F_BITS-1:0]        r_f;
    logic [F_BITS-1:0]        r_hphase;
    logic [2:0]               r_k;
    logic [2:0]               r_last;
    logic signed [W_BITS-1:0] r_w;
    logic [ADDR_BITS-1:0]     r_addr;
    logic                     r_neg;
    logic [ROM_BITS-1:0]      r_rom_q;
    logic [OUT_BITS-1:0]      r_res;

    logic [47:0]              ext48;
    logic [F_BITS-1:0]        f_now;
    logic signed [W_BITS-1:0] one_q30;
    logic signed [W_BITS-1:0] tri_d;
    logic signed [W_BITS-1:0] w_direct;
    logic                     harm_mode;
    logic [2:0]               n_last;
    logic [TABLE_BITS-1:0]    tab_idx;
    logic [ADDR_BITS-1:0]     n_addr;
    logic signed [W_BITS-1:0] rom_ext;
    logic signed [W_BITS-1:0] harm_a;
    logic signed [P_BITS:0]   rnd_sum;
    logic signed [Y_BITS-1:0] rnd_y;
    logic [OUT_BITS-1:0]      n_res;
    logic                     tick_acc;
    logic                     out_free;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    assign tick_acc     = i_tick_valid && !o_tick_stall;
    assign o_tick_stall = (r_state != S_IDLE);
    assign out_free     = !o_sample_valid || !i_sample_stall;

    // phase as a 32-bit fraction of a cycle, whatever the accumulator length
    assign ext48 = 48'(r_phase) << (48 - PHASE_BITS);
    assign f_now = ext48[47:16];

    assign one_q30 = W_BITS'(ONE_Q30_U);

    // waves that need no table, in Q30; table waves only pick harmonic mode and count
    always_comb begin
        tri_d     = $signed(W_BITS'(f_now)) - one_q30;
        harm_mode = 1'b0;
        n_last    = 3'd0;
        w_direct  = '0;
        case (r_sel)
            WAVE_SQUARE: begin
                w_direct = f_now[F_BITS-1] ? -one_q30 : one_q30;
            end
            WAVE_TRIANGLE: begin
                w_direct = (tri_d[W_BITS-1] ? -tri_d : tri_d) - (one_q30 >>> 1);
            end
            WAVE_SAWTOOTH: begin
                w_direct = $signed(W_BITS'(f_now[F_BITS-1:1])) - one_q30;
            end
            WAVE_SINE: begin
                harm_mode = 1'b1;
                n_last    = 3'd0;
            end
            WAVE_COMPOSITE: begin
                harm_mode = 1'b1;
                n_last    = 3'd2;
            end
            WAVE_BELL: begin
                harm_mode = 1'b1;
                n_last    = 3'd5;
            end
            default: begin
                w_direct = '0;
            end
        endcase
    end

    // quarter-wave addressing: mirror in odd quadrants, negate in the upper half of the phase
    assign tab_idx = r_hphase[F_BITS-3 -: TABLE_BITS];
    assign n_addr  = r_hphase[F_BITS-2]
                   ? ADDR_BITS'(QSIZE) - {1'b0, tab_idx}
                   : {1'b0, tab_idx};

    assign rom_ext = $signed(W_BITS'(r_rom_q));
    assign harm_a  = r_neg ? -rom_ext : rom_ext;

    // one shared multiplier: harmonic weight times sine, then wave times gain
    assign mul_req.start = (r_state == S_HGO) || (r_state == S_SCALE);
    assign mul_req.a     = (r_state == S_SCALE) ? r_w : harm_a;
    assign mul_req.b     = (r_state == S_SCALE) ? r_amp : f_coef(r_sel, r_k);

    mwto_dmul u_dmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // round half up out of Q30, then clip to Q3.15
    assign rnd_sum = (P_BITS+1)'($signed(mul_rsp.prod)) + (P_BITS+1)'(ONE_Q30_U >> 1);
    assign rnd_y   = rnd_sum[P_BITS:Q_SHIFT];

    always_comb begin
        if (rnd_y > $signed(Y_BITS'((64'd1 << (OUT_BITS - 1)) - 64'd1))) begin
            n_res = {1'b0, {(OUT_BITS-1){1'b1}}};
        end else if (rnd_y < -$signed(Y_BITS'(64'd1 << (OUT_BITS - 1)))) begin
            n_res = {1'b1, {(OUT_BITS-1){1'b0}}};
        end else begin
            n_res = rnd_y[OUT_BITS-1:0];
        end
    end

    // sine rom, registered read
    always_ff @(posedge i_clk) begin
        r_rom_q <= C_SINE_ROM[r_addr];
    end

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= RST_PHASE_STEP;
            r_amp  <= RST_AMPLITUDE;
            r_sel  <= RST_WAVE_SELECT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PHASE_STEP:  r_step <= i_cfg_data;
                CFG_AMPLITUDE:   r_amp  <= i_cfg_data[15:0];
                CFG_WAVE_SELECT: r_sel  <= i_cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    // sequencer, phase accumulator and sample register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_phase        <= '0;
            o_sample_valid <= 1'b0;
        end else begin
            // a taken sample leaves, unless the output step refills the register
            if (o_sample_valid && !i_sample_stall && (r_state != S_OUT)) begin
                o_sample_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    // a tick of zero is taken and leaves everything alone
                    if (tick_acc && i_tick) begin
                        r_f      <= f_now;
                        r_hphase <= f_now;
                        r_k      <= 3'd0;
                        r_last   <= n_last;
                        r_phase  <= r_phase + PHASE_BITS'(r_step);
                        if (harm_mode) begin
                            r_w     <= '0;
                            r_state <= S_ADDR;
                        end else begin
                            r_w     <= w_direct;
                            r_state <= S_SCALE;
                        end
                    end
                end
                S_ADDR: begin
                    r_addr   <= n_addr;
                    r_neg    <= r_hphase[F_BITS-1];
                    // next harmonic phase is (k+2)*f, wrapping
                    r_hphase <= r_hphase + r_f;
                    r_state  <= S_ROM;
                end
                S_ROM: begin
                    r_state <= S_HGO;
                end
                S_HGO: begin
                    r_state <= S_HMUL;
                end
                S_HMUL: begin
                    if (mul_rsp.done) begin
                        r_w <= r_w + $signed(mul_rsp.prod[W_BITS-1:0]);
                        r_k <= r_k + 1'b1;
                        if (r_k == r_last) begin
                            r_state <= S_SCALE;
                        end else begin
                            r_state <= S_ADDR;
                        end
                    end
                end
                S_SCALE: begin
                    r_state <= S_AMUL;
                end
                S_AMUL: begin
                    if (mul_rsp.done) begin
                        r_res   <= n_res;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // wait for the sample register to empty
                    if (out_free) begin
                        o_sample       <= $signed(r_res);
                        o_sample_valid <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### src/mwto_chk.sv
`default_nettype none

module mwto_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_tick_valid,
    input logic                          o_tick_stall,
    input logic                          i_tick,
    input logic                          o_sample_valid,
    input logic                          i_sample_stall,
    input logic [mwto_pkg::OUT_BITS-1:0] o_sample
);
    import mwto_pkg::*;

    // a held sample stays put until taken
    a_sample_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sample_valid && i_sample_stall |=> o_sample_valid && $stable(o_sample))
        else $error("sample dropped or changed while stalled");

    // a real tick starts work, so the request side closes
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick_valid && !o_tick_stall && i_tick |=> o_tick_stall)
        else $error("tick request did not start a sample");

    // a zero tick does no work
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick_valid && !o_tick_stall && !i_tick |=> !o_tick_stall)
        else $error("zero tick occupied the block");

    // a new sample only comes out of work in progress
    a_sample_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_sample_valid) |-> $past(o_tick_stall))
        else $error("sample appeared with no request in flight");

    // nothing pending straight after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_sample_valid && !o_tick_stall)
        else $error("state not cleared by reset");

endmodule

bind multi_waveform_tone_oscillator_unit mwto_chk u_mwto_chk (.*);

`default_nettype wire

### verif/multi_waveform_tone_oscillator_unit_tb.sv
module multi_waveform_tone_oscillator_unit_tb;

    import mwto_pkg::*;

    // tb-side geometry and fixed-point constants
    localparam int          LUT_SIZE       = 1 << TABLE_BITS;
    localparam logic [63:0] QUARTER_Q30    = 64'd1686629713;
    localparam logic [63:0] UNIT_Q30       = 64'd1 << 30;
    localparam longint      SAT_HI         = 262143;
    localparam longint      SAT_LO         = -262144;
    localparam logic [2:0]  WAVE_UNUSED_LO = 3'd6;
    localparam logic [2:0]  WAVE_UNUSED_HI = 3'd7;
    localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_IDX = 2'd3;

    // settle margin, sized for the longest path (bell)
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_TICKS  = 520;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int REPORT_MAX    = 10;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_cfg_we       = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx      = CFG_PHASE_STEP;
    logic [CFG_DATA_BITS-1:0] i_cfg_data     = '0;
    logic                     i_tick_valid   = 1'b0;
    logic                     i_tick         = 1'b0;
    logic                     i_sample_stall = 1'b0;
    logic                     o_tick_stall;
    logic                     o_sample_valid;
    logic signed [OUT_BITS-1:0] o_sample;

    multi_waveform_tone_oscillator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_tick_valid   (i_tick_valid),
        .o_tick_stall   (o_tick_stall),
        .i_tick         (i_tick),
        .o_sample_valid (o_sample_valid),
        .i_sample_stall (i_sample_stall),
        .o_sample       (o_sample)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // tb copy of the oscillator state and its registers
    logic [31:0] phase_acc;
    logic [31:0] step_reg;
    logic [15:0] gain_reg;
    logic [2:0]  shape_reg;
    int          sine_quarter [0:LUT_SIZE];

    logic signed [OUT_BITS-1:0] pending_samples [$];

    int  failures       = 0;
    int  samples_seen   = 0;
    int  requests_sent  = 0;
    int  idle_requests  = 0;
    int  settings_count = 0;
    int  cycle_count    = 0;
    int  sink_hold      = 0;
    bit  back_to_back   = 1'b0;

    // quarter-wave sine in q15, taylor series evaluated in q30
    function automatic void build_sine_quarter();
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] q;
        for (int i = 0; i <= LUT_SIZE; i++) begin
            x  = (64'(i) * QUARTER_Q30) >> TABLE_BITS;
            x2 = (x * x) >> 30;
            t  = UNIT_Q30 - x2 / 72;
            t  = UNIT_Q30 - ((x2 * t) >> 30) / 42;
            t  = UNIT_Q30 - ((x2 * t) >> 30) / 20;
            t  = UNIT_Q30 - ((x2 * t) >> 30) / 6;
            s  = (x * t) >> 30;
            q  = (s + 64'd16384) >> 15;
            if (q > 64'd32768) begin
                q = 64'd32768;
            end
            sine_quarter[i] = int'(q);
        end
    endfunction

    // signed q15 sine of a 32-bit phase fraction, mirrored per quadrant
    function automatic longint sine_of(input logic [31:0] f);
        logic [1:0]            quad;
        logic [TABLE_BITS-1:0] idx;
        longint                v;
        quad = f[31:30];
        idx  = f[29:30-TABLE_BITS];
        if (quad[0]) begin
            v = longint'(sine_quarter[LUT_SIZE - int'(idx)]);
        end else begin
            v = longint'(sine_quarter[idx]);
        end
        return quad[1] ? -v : v;
    endfunction

    // q1.15 weight of harmonic k (1-based); zero beyond the wave's harmonic count
    function automatic longint harmonic_weight(input logic [2:0] shape, input int k);
        longint c;
        c = 0;
        if (shape == WAVE_COMPOSITE) begin
            case (k)
                1:       c = 32768;
                2:       c = 16384;
                3:       c = 8192;
                default: c = 0;
            endcase
        end else if (shape == WAVE_BELL) begin
            case (k)
                1:       c = 32768;
                2:       c = 16384;
                3:       c = 10813;
                4:       c = 8192;
                5:       c = 5243;
                6:       c = 4260;
                default: c = 0;
            endcase
        end
        return c;
    endfunction

    // waveform value in q30 for the current shape
    function automatic longint shape_q30(input logic [31:0] f, input logic [2:0] shape);
        longint      w;
        longint      d;
        logic [31:0] hf;
        w = 0;
        case (shape)
            WAVE_SQUARE:   w = f[31] ? -(longint'(1) << 30) : (longint'(1) << 30);
            WAVE_TRIANGLE: begin
                d = longint'({32'd0, f}) - (longint'(1) << 30);
                w = (d < 0 ? -d : d) - (longint'(1) << 29);
            end
            WAVE_SAWTOOTH: w = longint'({33'd0, f[31:1]}) - (longint'(1) << 30);
            WAVE_SINE:     w = sine_of(f) * 32768;
            WAVE_COMPOSITE, WAVE_BELL: begin
                for (int k = 1; k <= 6; k++) begin
                    hf = f * 32'(k);
                    w += harmonic_weight(shape, k) * sine_of(hf);
                end
            end
            default:       w = 0;
        endcase
        return w;
    endfunction

    // gain, round half up, saturate to q3.15
    function automatic logic signed [OUT_BITS-1:0] tone_sample(input logic [31:0] f);
        longint y;
        y = (shape_q30(f, shape_reg) * longint'({48'd0, gain_reg}) + (longint'(1) << 29))
            >>> 30;
        if (y > SAT_HI) y = SAT_HI;
        if (y < SAT_LO) y = SAT_LO;
        return y[OUT_BITS-1:0];
    endfunction

    function automatic int draw_wait();
        return back_to_back ? 0 : $urandom_range(0, 19);
    endfunction

    // sample sink: random stall after every accepted sample, compare against oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_sample_valid && !i_sample_stall) begin
                samples_seen++;
                if (pending_samples.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_MAX) begin
                        $display("unexpected sample %0d with nothing pending", o_sample);
                    end
                end else if (o_sample !== pending_samples[0]) begin
                    failures++;
                    if (failures <= REPORT_MAX) begin
                        $display("sample %0d: expected %0d, got %0d",
                                 samples_seen, pending_samples[0], o_sample);
                    end
                    void'(pending_samples.pop_front());
                end else begin
                    void'(pending_samples.pop_front());
                end
                sink_hold = draw_wait();
            end
            if (sink_hold > 0) begin
                i_sample_stall <= 1'b1;
                sink_hold--;
            end else begin
                i_sample_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("multi_waveform_tone_oscillator_unit_tb: errors");
            $finish;
        end
    end

    // one tick request; valid is only lowered when a gap is drawn
    task automatic send_tick(input logic tick_bit);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_tick_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_tick_valid <= 1'b1;
        i_tick       <= tick_bit;
        @(posedge i_clk);
        while (o_tick_stall) @(posedge i_clk);
        requests_sent++;
        if (tick_bit) begin
            pending_samples.push_back(tone_sample(phase_acc));
            phase_acc = phase_acc + step_reg;
        end else begin
            idle_requests++;
        end
    endtask

    // let every pending sample out, then allow for an idle request still in flight
    task automatic drain();
        i_tick_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_PHASE_STEP:  step_reg  = data;
            CFG_AMPLITUDE:   gain_reg  = data[15:0];
            CFG_WAVE_SELECT: shape_reg = data[2:0];
            default:         ;
        endcase
    endtask

    task automatic cfg_close();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    task automatic set_regs(input logic [31:0] step, input logic [31:0] gain,
                            input logic [31:0] shape);
        drain();
        cfg_write(CFG_PHASE_STEP, step);
        cfg_write(CFG_AMPLITUDE, gain);
        cfg_write(CFG_WAVE_SELECT, shape);
        cfg_close();
    endtask

    // composite wave, zero step, unit gain straight out of reset
    task automatic test_reset_state();
        send_tick(1'b1);
        send_tick(1'b1);
    endtask

    // every select code once, unused codes included, on a stepping phase
    task automatic test_wave_shapes();
        for (int w = WAVE_SQUARE; w <= WAVE_UNUSED_HI; w++) begin
            set_regs(32'h2AAA_AAAB, 32'd32768, 32'(w));
            send_tick(1'b1);
        end
    endtask

    // a tick of zero gives no sample and leaves the phase alone
    task automatic test_idle_tick();
        set_regs(32'h1234_5678, 32'd32768, {29'd0, WAVE_SAWTOOTH});
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    // zero gain and the largest gain the register holds
    task automatic test_gain_extremes();
        set_regs(32'h4000_0000, 32'd0, {29'd0, WAVE_SQUARE});
        send_tick(1'b1);
        set_regs(32'h4000_0000, 32'hFFFF_FFFF, {29'd0, WAVE_TRIANGLE});
        send_tick(1'b1);
        set_regs(32'h0B00_0000, 32'd65535, {29'd0, WAVE_BELL});
        send_tick(1'b1);
    endtask

    // writes to the spare index must change nothing
    task automatic test_unused_index();
        drain();
        cfg_write(CFG_UNUSED_IDX, 32'hFFFF_FFFF);
        cfg_close();
        send_tick(1'b1);
    endtask

    // full-scale step: phase walks backwards by one lsb per sample
    task automatic test_step_extremes();
        set_regs(32'hFFFF_FFFF, 32'd32768, {29'd0, WAVE_SINE});
        send_tick(1'b1);
        send_tick(1'b1);
    endtask

    // random register settings, each followed by a burst of mostly live ticks
    task automatic test_random_sweeps();
        int          live;
        int          burst_len;
        logic [31:0] step;
        logic [31:0] gain;
        logic [31:0] shape;
        live = 0;
        while (live < RANDOM_TICKS) begin
            case ($urandom_range(0, 4))
                0:       step = 32'd0;
                1:       step = 32'hFFFF_FFFF;
                2:       step = $urandom_range(1, 1 << 24);
                default: step = $urandom();
            endcase
            case ($urandom_range(0, 5))
                0:       gain = 32'd0;
                1:       gain = 32'd32768;
                2:       gain = 32'd65535;
                5:       gain = $urandom();
                default: gain = $urandom_range(0, 32768);
            endcase
            // junk above the register widths must be dropped
            gain[31:16] = 16'($urandom());
            if ($urandom_range(0, 9) == 0) begin
                shape = $urandom_range(WAVE_UNUSED_LO, WAVE_UNUSED_HI);
            end else begin
                shape = $urandom_range(WAVE_SQUARE, WAVE_BELL);
            end
            shape[31:3] = 29'($urandom());
            set_regs(step, gain, shape);
            if ($urandom_range(0, 3) == 0) begin
                drain();
                cfg_write(CFG_UNUSED_IDX, $urandom());
                cfg_close();
            end
            back_to_back = ($urandom_range(0, 3) == 0);
            burst_len    = $urandom_range(20, 70);
            for (int n = 0; n < burst_len; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_tick(1'b0);
                end else begin
                    send_tick(1'b1);
                    live++;
                end
            end
            back_to_back = 1'b0;
        end
    endtask

    initial begin
        build_sine_quarter();
        phase_acc = '0;
        step_reg  = RST_PHASE_STEP;
        gain_reg  = RST_AMPLITUDE;
        shape_reg = RST_WAVE_SELECT;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_wave_shapes();
        test_idle_tick();
        test_gain_extremes();
        test_unused_index();
        test_step_extremes();
        test_random_sweeps();

        drain();
        $display("%0d tick requests (%0d idle), %0d samples checked", requests_sent,
                 idle_requests, samples_seen);
        $display("%0d register settings over all six waves, spare codes and gain extremes",
                 settings_count);
        if (failures == 0 && pending_samples.size() == 0) begin
            $display("multi_waveform_tone_oscillator_unit_tb: clean");
        end else begin
            $display("%0d failures, %0d samples never arrived", failures,
                     pending_samples.size());
            $display("multi_waveform_tone_oscillator_unit_tb: errors");
        end
        $finish;
    end

endmodule
